### rtl/core/c2p_pkg.sv
// Shared constants, types and the arctangent table of the Cartesian-to-polar unit.
// Used by all modules under rtl/core; depends on nothing.
package c2p_pkg;

	localparam int ITERATIONS = 16;
	localparam int PIPE_DEPTH = ITERATIONS + 3;
	localparam int GUARD      = 14;
	localparam int XY_W       = 32;
	localparam int Z_W        = 28;
	localparam int PROD_W     = 49;
	localparam int ANG_W      = 19;
	localparam int WRAP_W     = 20;

	localparam logic signed [Z_W-1:0]    PI_ACC      = 28'sd52707179;
	localparam logic signed [16:0]       INV_GAIN    = 17'sd39797;
	localparam logic [15:0]              OFFSET_RST  = 16'd14694;
	localparam logic signed [WRAP_W-1:0] PI_BIAS     = 20'sd25735;
	localparam logic signed [WRAP_W-1:0] TWO_PI      = 20'sd51472;
	localparam logic signed [WRAP_W-1:0] FOUR_PI     = 20'sd102944;
	localparam logic signed [15:0]       PI_Q13      = 16'sd25736;
	localparam logic signed [18:0]       MAG_MAX     = 19'sd65535;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} cordic_t;

	function automatic logic signed [Z_W-1:0] atan_val(input int unsigned k);
		case (k)
			0:       atan_val = 28'sd13176795;
			1:       atan_val = 28'sd7778716;
			2:       atan_val = 28'sd4110060;
			3:       atan_val = 28'sd2086331;
			4:       atan_val = 28'sd1047214;
			5:       atan_val = 28'sd524117;
			6:       atan_val = 28'sd262123;
			7:       atan_val = 28'sd131069;
			8:       atan_val = 28'sd65536;
			9:       atan_val = 28'sd32768;
			10:      atan_val = 28'sd16384;
			11:      atan_val = 28'sd8192;
			12:      atan_val = 28'sd4096;
			13:      atan_val = 28'sd2048;
			14:      atan_val = 28'sd1024;
			15:      atan_val = 28'sd512;
			16:      atan_val = 28'sd256;
			17:      atan_val = 28'sd128;
			18:      atan_val = 28'sd64;
			19:      atan_val = 28'sd32;
			20:      atan_val = 28'sd16;
			21:      atan_val = 28'sd8;
			22:      atan_val = 28'sd4;
			23:      atan_val = 28'sd2;
			default: atan_val = '0;
		endcase
	endfunction

endpackage

### rtl/core/c2p_if.sv
// Valid/ready channels of the Cartesian-to-polar unit: point requests in, polar results out.
// Standalone; no package dependency.
interface c2p_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if;
	logic               valid;
	logic               ready;
	logic        [15:0] magnitude;
	logic signed [15:0] angle;
	logic               zero_vector;

	modport source (output valid, output magnitude, output angle, output zero_vector,
		input ready);
	modport sink   (input valid, input magnitude, input angle, input zero_vector,
		output ready);
endinterface

### rtl/core/c2p_pre.sv
// Input stage: folds left half-plane points into the right half-plane and adds guard bits.
// Depends on c2p_pkg.
module c2p_pre (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [15:0]        x_coord,
	input  logic signed [15:0]        y_coord,
	output c2p_pkg::cordic_t          dout
);

	logic signed [16:0] xe;
	logic signed [16:0] ye;
	logic signed [16:0] xn;
	logic signed [16:0] yn;
	logic               neg;
	c2p_pkg::cordic_t   nxt;
	c2p_pkg::cordic_t   pre_s0;

	always_comb begin
		xe       = {x_coord[15], x_coord};
		ye       = {y_coord[15], y_coord};
		neg      = x_coord[15];
		xn       = neg ? -xe : xe;
		yn       = neg ? -ye : ye;
		nxt.x    = {{(c2p_pkg::XY_W - 17 - c2p_pkg::GUARD){xn[16]}}, xn,
			{c2p_pkg::GUARD{1'b0}}};
		nxt.y    = {{(c2p_pkg::XY_W - 17 - c2p_pkg::GUARD){yn[16]}}, yn,
			{c2p_pkg::GUARD{1'b0}}};
		nxt.z    = neg ? c2p_pkg::PI_ACC : '0;
		nxt.zero = (x_coord == '0) && (y_coord == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s0 <= nxt;
		end
	end

	assign dout = pre_s0;

endmodule

### rtl/core/c2p_cordic.sv
// Vectoring CORDIC pipeline: one micro-rotation and one register per iteration.
// Depends on c2p_pkg for the iteration count, data type and arctangent table.
module c2p_cordic (
	input  logic                              clk,
	input  logic [c2p_pkg::ITERATIONS-1:0]    en,
	input  c2p_pkg::cordic_t                  din,
	output c2p_pkg::cordic_t                  dout
);

	c2p_pkg::cordic_t rot_s [c2p_pkg::ITERATIONS];

	for (genvar i = 0; i < c2p_pkg::ITERATIONS; i++) begin : g_rot
		c2p_pkg::cordic_t           src;
		c2p_pkg::cordic_t           nxt;
		logic signed [c2p_pkg::XY_W-1:0] dx;
		logic signed [c2p_pkg::XY_W-1:0] dy;

		if (i == 0) begin : g_first
			assign src = din;
		end else begin : g_next
			assign src = rot_s[i-1];
		end

		always_comb begin
			dx       = src.x >>> i;
			dy       = src.y >>> i;
			nxt.zero = src.zero;
			if (!src.y[c2p_pkg::XY_W-1]) begin
				nxt.x = src.x + dy;
				nxt.y = src.y - dx;
				nxt.z = src.z + c2p_pkg::atan_val(i);
			end else begin
				nxt.x = src.x - dy;
				nxt.y = src.y + dx;
				nxt.z = src.z - c2p_pkg::atan_val(i);
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rot_s[i] <= nxt;
			end
		end
	end

	assign dout = rot_s[c2p_pkg::ITERATIONS-1];

endmodule

### rtl/core/c2p_post.sv
// Output stages: gain compensation, offset add with rounding, saturation and angle wrap.
// Depends on c2p_pkg; the second stage is the result register.
module c2p_post (
	input  logic                  clk,
	input  logic [1:0]            en,
	input  logic [15:0]           phase_offset,
	input  c2p_pkg::cordic_t      din,
	output logic [15:0]           magnitude,
	output logic signed [15:0]    angle,
	output logic                  zero_vector
);

	logic signed [c2p_pkg::PROD_W-1:0] prod_s1;
	logic signed [c2p_pkg::ANG_W-1:0]  ang_s1;
	logic                              zero_s1;

	logic [15:0]                       mag_s2;
	logic signed [15:0]                ang_s2;
	logic                              zero_s2;

	logic signed [c2p_pkg::Z_W-1:0]    z_use;
	logic signed [29:0]                ang_sum;
	logic signed [c2p_pkg::PROD_W-1:0] rnd;
	logic signed [18:0]                mag_w;
	logic [15:0]                       mag_nxt;
	logic signed [c2p_pkg::WRAP_W-1:0] t;
	logic signed [c2p_pkg::WRAP_W-1:0] t_red;
	logic signed [c2p_pkg::WRAP_W-1:0] ang_w;

	always_comb begin
		z_use   = din.zero ? '0 : din.z;
		ang_sum = 30'(z_use) + {3'b000, phase_offset, 11'b0} + 30'sd1024;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= din.x * c2p_pkg::INV_GAIN;
			ang_s1  <= ang_sum[29:11];
			zero_s1 <= din.zero;
		end
	end

	always_comb begin
		rnd   = prod_s1 + (49'sd1 <<< 29);
		mag_w = rnd[48:30];
		if (mag_w[18]) begin
			mag_nxt = '0;
		end else if (mag_w > c2p_pkg::MAG_MAX) begin
			mag_nxt = 16'hFFFF;
		end else begin
			mag_nxt = mag_w[15:0];
		end

		t = {ang_s1[c2p_pkg::ANG_W-1], ang_s1} + c2p_pkg::PI_BIAS;
		if (t < 0) begin
			t_red = t + c2p_pkg::TWO_PI;
		end else if (t >= c2p_pkg::FOUR_PI) begin
			t_red = t - c2p_pkg::FOUR_PI;
		end else if (t >= c2p_pkg::TWO_PI) begin
			t_red = t - c2p_pkg::TWO_PI;
		end else begin
			t_red = t;
		end
		ang_w = t_red - c2p_pkg::PI_BIAS;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_s2  <= zero_s1 ? '0 : mag_nxt;
			ang_s2  <= ang_w[15:0];
			zero_s2 <= zero_s1;
		end
	end

	assign magnitude   = mag_s2;
	assign angle       = ang_s2;
	assign zero_vector = zero_s2;

endmodule

### rtl/core/cartesian_to_polar_phase_offset_unit.sv
// Cartesian-to-polar unit: vectoring CORDIC with a configurable phase offset.
// Pipeline: input stage, one stage per CORDIC micro-rotation, then the output stages.
// Throughput: one request per cycle unless the pipe is full behind a stalled output.
// A stalled output holds its result; empty stages keep accepting until the pipe is full.
// Reset clears all stage valid bits and loads the phase offset with 14694.
module cartesian_to_polar_phase_offset_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	c2p_in_if.sink           pnt,
	c2p_out_if.source        pol
);

	localparam int DEPTH = c2p_pkg::PIPE_DEPTH;

	logic [15:0]      phase_offset_q;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] en;
	logic [DEPTH-1:0] vld_in;
	c2p_pkg::cordic_t pre_d;
	c2p_pkg::cordic_t rot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_offset_q <= c2p_pkg::OFFSET_RST;
		end else if (cfg_wr_en) begin
			phase_offset_q <= cfg_wr_data;
		end
	end

	// advance a stage when it is empty or the stage after it moves
	for (genvar k = 0; k < DEPTH; k++) begin : g_en
		assign en[k] = pol.ready || !(&vld_q[DEPTH-1:k]);
	end

	assign vld_in = {vld_q[DEPTH-2:0], pnt.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_in & en) | (vld_q & ~en);
		end
	end

	assign pnt.ready = en[0];
	assign pol.valid = vld_q[DEPTH-1];

	c2p_pre u_pre (
		.clk     (clk),
		.en      (en[0]),
		.x_coord (pnt.x_coord),
		.y_coord (pnt.y_coord),
		.dout    (pre_d)
	);

	c2p_cordic u_cordic (
		.clk  (clk),
		.en   (en[c2p_pkg::ITERATIONS:1]),
		.din  (pre_d),
		.dout (rot_d)
	);

	c2p_post u_post (
		.clk          (clk),
		.en           (en[DEPTH-1:DEPTH-2]),
		.phase_offset (phase_offset_q),
		.din          (rot_d),
		.magnitude    (pol.magnitude),
		.angle        (pol.angle),
		.zero_vector  (pol.zero_vector)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pnt.ready |-> (&vld_q))
		else $error("request stalled while a pipeline stage is empty");

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		pol.valid && pol.zero_vector |-> pol.magnitude == '0)
		else $error("zero vector result with nonzero magnitude");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		pol.valid |-> (pol.angle > -c2p_pkg::PI_Q13) && (pol.angle <= c2p_pkg::PI_Q13))
		else $error("angle outside (-pi, pi]");

	a_zero_flag_in: assert property (@(posedge clk) disable iff (!arst_n)
		pnt.valid && pnt.ready && (pnt.x_coord == '0) && (pnt.y_coord == '0)
		|=> vld_q[0] && pre_d.zero)
		else $error("zero vector request not flagged in input stage");

endmodule

### tb/cartesian_to_polar_phase_offset_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the Cartesian-to-polar unit: points in, magnitude and offset angle out.
// Depends on c2p_pkg, the c2p_in_if / c2p_out_if channels and the unit's top level.
module cartesian_to_polar_phase_offset_unit_test;

	localparam longint HALF_TURN  = 25736;
	localparam longint FULL_TURN  = 51472;
	localparam longint PI_Q24_ACC = 52707179;
	localparam longint MAG_SCALE  = 39797;
	localparam int     IDLE_PCT   = 38;
	localparam int     HOLD_LEN   = 150;
	localparam int     PHASE_LEN  = 66;

	typedef struct packed {
		logic        [15:0] magnitude;
		logic signed [15:0] angle;
		logic               zero_vector;
	} polar_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               fixed;
		polar_t             want;
	} point_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	c2p_in_if  pnt();
	c2p_out_if pol();

	cartesian_to_polar_phase_offset_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pnt         (pnt),
		.pol         (pol)
	);

	longint atan_q24 [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	point_row_t directed_rows [20] = '{
		'{16'sd0,      16'sd0,      1'b1, '{16'd0, 16'sd14694, 1'b1}},
		'{16'sd32767,  16'sd0,      1'b0, '0},
		'{-16'sd32768, 16'sd0,      1'b0, '0},
		'{-16'sd1,     16'sd0,      1'b0, '0},
		'{16'sd0,      16'sd32767,  1'b0, '0},
		'{16'sd0,      -16'sd32768, 1'b0, '0},
		'{16'sd32767,  16'sd32767,  1'b0, '0},
		'{-16'sd32768, -16'sd32768, 1'b0, '0},
		'{-16'sd32768, 16'sd32767,  1'b0, '0},
		'{16'sd32767,  -16'sd32768, 1'b0, '0},
		'{16'sd1,      16'sd0,      1'b0, '0},
		'{16'sd0,      16'sd1,      1'b0, '0},
		'{-16'sd1,     -16'sd1,     1'b0, '0},
		'{16'sd1,      -16'sd1,     1'b0, '0},
		'{-16'sd32768, 16'sd1,      1'b0, '0},
		'{-16'sd32768, -16'sd1,     1'b0, '0},
		'{16'sd23170,  16'sd23170,  1'b0, '0},
		'{-16'sd12345, 16'sd6789,   1'b0, '0},
		'{16'sd21845,  -16'sd10922, 1'b0, '0},
		'{16'sd0,      16'sd0,      1'b1, '{16'd0, 16'sd14694, 1'b1}}
	};

	polar_t      polar_q [$];
	logic [15:0] offset_model;
	int          fails;
	bit          steady;
	bit          hold_req;

	function automatic longint wrap_turn(input longint a);
		longint t;
		t = (a + HALF_TURN - 1) % FULL_TURN;
		if (t < 0)
			t += FULL_TURN;
		return t - (HALF_TURN - 1);
	endfunction

	function automatic polar_t to_polar(input logic signed [15:0] xc, input logic signed [15:0] yc,
		input logic [15:0] ofs);
		longint x, y, z, dx, dy, mag, ang;
		polar_t r;
		r = '0;
		if (xc == 0 && yc == 0) begin
			r.angle       = 16'(wrap_turn(longint'(ofs)));
			r.zero_vector = 1'b1;
			return r;
		end
		x = xc;
		y = yc;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = PI_Q24_ACC;
		end
		x = x * 16384;
		y = y * 16384;
		for (int i = 0; i < c2p_pkg::ITERATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += atan_q24[i];
			end else begin
				x -= dx;
				y += dy;
				z -= atan_q24[i];
			end
		end
		mag = (x * MAG_SCALE + (64'sd1 <<< 29)) >>> 30;
		if (mag > 65535)
			mag = 65535;
		if (mag < 0)
			mag = 0;
		ang = z + longint'(ofs) * 2048;
		ang = wrap_turn((ang + 1024) >>> 11);
		r.magnitude = 16'(mag);
		r.angle     = 16'(ang);
		return r;
	endfunction

	function automatic logic signed [15:0] edge_value();
		case ($urandom_range(4))
			0:       return -16'sd32768;
			1:       return -16'sd1;
			2:       return 16'sd0;
			3:       return 16'sd1;
			default: return 16'sd32767;
		endcase
	endfunction

	task automatic offer_point(input logic signed [15:0] x, input logic signed [15:0] y,
		input polar_t want);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pnt.valid <= 1'b0;
			@(negedge clk);
		end
		pnt.valid   <= 1'b1;
		pnt.x_coord <= x;
		pnt.y_coord <= y;
		do
			@(posedge clk);
		while (!pnt.ready);
		polar_q.push_back(want);
		@(negedge clk);
	endtask

	task automatic random_point();
		logic signed [15:0] x, y;
		case ($urandom_range(19))
			0: begin
				x = 0;
				y = 0;
			end
			1, 2: begin
				x = 16'($urandom_range(65535));
				y = 0;
				if ($urandom_range(1))
					{x, y} = {y, x};
			end
			3, 4: begin
				x = edge_value();
				y = edge_value();
			end
			5, 6: begin
				x = 16'(int'($urandom_range(128)) - 64);
				y = 16'(int'($urandom_range(128)) - 64);
			end
			default: begin
				x = 16'($urandom_range(65535));
				y = 16'($urandom_range(65535));
			end
		endcase
		offer_point(x, y, to_polar(x, y, offset_model));
	endtask

	task automatic write_offset(input logic [15:0] value);
		pnt.valid <= 1'b0;
		while (polar_q.size() != 0)
			@(negedge clk);
		cfg_wr_en    <= 1'b1;
		cfg_wr_data  <= value;
		offset_model = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		pol.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pol.ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
			end
			pol.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : check_results
		polar_t want;
		if (arst_n && pol.valid && pol.ready) begin
			if (polar_q.size() == 0) begin
				$error("result with no request pending: magnitude %0d angle %0d zero_vector %0b",
					pol.magnitude, pol.angle, pol.zero_vector);
				fails++;
			end else begin
				want = polar_q.pop_front();
				if (pol.magnitude !== want.magnitude) begin
					$error("magnitude: expected %0d, got %0d", want.magnitude, pol.magnitude);
					fails++;
				end
				if (pol.angle !== want.angle) begin
					$error("angle: expected %0d, got %0d", want.angle, pol.angle);
					fails++;
				end
				if (pol.zero_vector !== want.zero_vector) begin
					$error("zero_vector: expected %0b, got %0b", want.zero_vector,
						pol.zero_vector);
					fails++;
				end
			end
		end
	end

	initial begin
		logic [15:0] phase_offsets [9];
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		pnt.valid    = 1'b0;
		pnt.x_coord  = '0;
		pnt.y_coord  = '0;
		fails        = 0;
		steady       = 1'b0;
		hold_req     = 1'b0;
		offset_model = c2p_pkg::OFFSET_RST;
		phase_offsets = '{16'd0, 16'd51472, 16'd65535, 16'd25736, 16'd25735, 16'd1,
			16'($urandom_range(65535)), 16'($urandom_range(51472)), 16'd14694};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_point(directed_rows[i].x, directed_rows[i].y,
				directed_rows[i].fixed ? directed_rows[i].want
				: to_polar(directed_rows[i].x, directed_rows[i].y, offset_model));

		foreach (phase_offsets[p]) begin
			write_offset(phase_offsets[p]);
			steady   = (p == 2);
			hold_req = (p == 1 || p == 5);
			offer_point(16'sd0, 16'sd0, to_polar(16'sd0, 16'sd0, offset_model));
			repeat (PHASE_LEN) random_point();
		end
		steady = 1'b0;

		pnt.valid <= 1'b0;
		while (polar_q.size() != 0)
			@(posedge clk);
		repeat (c2p_pkg::PIPE_DEPTH + 8) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
